// ===== hdl/lbme_pkg.sv =====
package lbme_pkg;

  // Widths of the item fields and of the configuration port.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DATA_W     = 7;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 56;

  // The configuration registers always hold four voices of eight slots.
  localparam int unsigned MAX_VOICES = 4;
  localparam int unsigned VOICE_W    = 2;
  localparam int unsigned MAX_SLOTS  = 8;
  localparam int unsigned SLOT_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_MULTI_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_SCALING     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBERS0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBERS1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBERS2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBERS3    = 3'd6;

  localparam logic [15:0] VOICE_CHANNELS_RESET = 16'h3210;

  typedef struct packed {
    logic [MAX_VOICES-1:0][CHAN_W-1:0]                voice_channels;
    logic [MAX_VOICES-1:0]                            cc_multi_mode;
    logic [MAX_VOICES-1:0]                            cc_scaling;
    logic [MAX_VOICES-1:0][MAX_SLOTS-1:0][DATA_W-1:0] cc_numbers;
  } cfg_t;

  // Work items passed from the front end to the event sequencer.
  typedef enum logic [2:0] {
    OP_CLOCK,
    OP_START,
    OP_STOP,
    OP_NOTE,
    OP_CC,
    OP_PROG
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [VOICE_W-1:0]  voice;
    logic [DATA_W-1:0]   data;
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NOTE_ON  = 3'd0,
    EV_NOTE_OFF = 3'd1,
    EV_CC       = 3'd2,
    EV_PROG     = 3'd3,
    EV_CLOCK    = 3'd4,
    EV_START    = 3'd5,
    EV_STOP     = 3'd6
  } evt_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NOTE_OFF,
    BK_NOTE_ON,
    BK_SINGLE,
    BK_STOP_OFF,
    BK_STOP_CC,
    BK_STOP_END
  } back_state_t;

endpackage

// ===== hdl/lbme_in_if.sv =====
interface lbme_in_if;
  logic                       valid;
  logic                       ready;
  logic [lbme_pkg::BYTE_W-1:0] link_byte;

  modport source (output valid, output link_byte, input ready);
  modport sink   (input valid, input link_byte, output ready);
endinterface

// ===== hdl/lbme_out_if.sv =====
interface lbme_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbme_pkg::KIND_W-1:0] event_kind;
  logic [lbme_pkg::CHAN_W-1:0] midi_channel;
  logic [lbme_pkg::DATA_W-1:0] first_data;
  logic [lbme_pkg::DATA_W-1:0] second_data;
  logic                        last_of_run;

  modport source (output valid, output event_kind, output midi_channel,
                  output first_data, output second_data, output last_of_run,
                  input ready);
  modport sink   (input valid, input event_kind, input midi_channel,
                  input first_data, input second_data, input last_of_run,
                  output ready);
endinterface

// ===== hdl/lbme_front.sv =====
module lbme_front #(
  parameter int unsigned VOICES = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  lbme_in_if.sink         in_ch,
  output logic            push,
  output lbme_pkg::op_t   push_op,
  input  logic            push_ready
);

  localparam logic [7:0] CMD_FIRST = 8'h70;
  localparam logic [7:0] CMD_CLOCK = 8'h7F;
  localparam logic [7:0] CMD_STOP  = 8'h7E;
  localparam logic [7:0] CMD_START = 8'h7D;
  localparam logic [7:0] CMD_LIMIT = 8'h0C;

  localparam logic [1:0] GRP_NOTE = 2'd0;
  localparam logic [1:0] GRP_CC   = 2'd1;
  localparam logic [1:0] GRP_PROG = 2'd2;

  logic [7:0] pending_cmd_r;
  logic [7:0] pending_cmd_nxt;
  logic       pending_valid_r;
  logic       pending_valid_nxt;
  logic       accept;
  logic [7:0] b;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign b           = in_ch.link_byte;

  always_comb begin
    push              = 1'b0;
    push_op.kind      = lbme_pkg::OP_CLOCK;
    push_op.voice     = pending_cmd_r[1:0];
    push_op.data      = b[6:0];
    pending_cmd_nxt   = pending_cmd_r;
    pending_valid_nxt = pending_valid_r;
    if (accept) begin
      if (b >= CMD_FIRST) begin
        if (b == CMD_CLOCK) begin
          push         = 1'b1;
          push_op.kind = lbme_pkg::OP_CLOCK;
        end else if (b == CMD_STOP) begin
          push         = 1'b1;
          push_op.kind = lbme_pkg::OP_STOP;
        end else if (b == CMD_START) begin
          push         = 1'b1;
          push_op.kind = lbme_pkg::OP_START;
        end else begin
          pending_cmd_nxt   = b - CMD_FIRST;
          pending_valid_nxt = 1'b1;
        end
      end else if (pending_valid_r) begin
        // Unknown commands and voices past the configured count are dropped.
        if (pending_cmd_r < CMD_LIMIT &&
            {1'b0, pending_cmd_r[1:0]} < 3'(VOICES)) begin
          push = 1'b1;
          unique case (pending_cmd_r[3:2])
            GRP_NOTE: push_op.kind = lbme_pkg::OP_NOTE;
            GRP_CC:   push_op.kind = lbme_pkg::OP_CC;
            GRP_PROG: push_op.kind = lbme_pkg::OP_PROG;
            default:  push         = 1'b0;
          endcase
        end
        pending_cmd_nxt   = '0;
        pending_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_cmd_r   <= '0;
      pending_valid_r <= 1'b0;
    end else begin
      pending_cmd_r   <= pending_cmd_nxt;
      pending_valid_r <= pending_valid_nxt;
    end
  end

endmodule

// ===== hdl/lbme_op_fifo.sv =====
module lbme_op_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lbme_pkg::op_t push_op,
  output logic          push_ready,
  input  logic          pop,
  output lbme_pkg::op_t head_op,
  output logic          head_valid
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lbme_pkg::op_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lbme_back.sv =====
module lbme_back #(
  parameter int unsigned VOICES   = 4,
  parameter int unsigned CC_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lbme_pkg::cfg_t cfg,
  input  lbme_pkg::op_t  head_op,
  input  logic           head_valid,
  output logic           pop,
  lbme_out_if.source     out_ch
);

  localparam int unsigned DW = lbme_pkg::DATA_W;
  localparam int unsigned VW = lbme_pkg::VOICE_W;

  localparam logic [DW-1:0] VEL_ON       = 7'h7F;
  localparam logic [DW-1:0] VEL_OFF      = 7'h40;
  localparam logic [DW-1:0] CC_ALL_OFF   = 7'd123;
  // floor(d * 16 / 111) equals (d * 1181) >> 13 for every data byte.
  localparam logic [17:0]   SCALE_RECIP  = 18'd1181;
  localparam int unsigned   SCALE_SHIFT  = 13;

  lbme_pkg::back_state_t state_r, state_nxt;
  lbme_pkg::op_t         op_r;
  logic [VW-1:0]         vc_r;
  logic [VOICES-1:0]     held_valid_r;
  logic [DW-1:0]         held_note_r [VOICES];

  logic                       out_valid_r;
  lbme_pkg::evt_kind_t        out_kind_r;
  logic [lbme_pkg::CHAN_W-1:0] out_chan_r;
  logic [DW-1:0]              out_d1_r;
  logic [DW-1:0]              out_d2_r;
  logic                       out_last_r;

  logic                        emit_ok;
  logic                        emit;
  lbme_pkg::evt_kind_t         ev_kind;
  logic [lbme_pkg::CHAN_W-1:0] ev_chan;
  logic [DW-1:0]               ev_d1;
  logic [DW-1:0]               ev_d2;
  logic                        ev_last;
  logic                        load;
  logic                        set_held;
  logic                        clr_held;
  logic                        vc_inc;

  logic [VW-1:0]               cur_voice;
  logic                        cur_held;
  logic [DW-1:0]               cur_note;
  logic                        head_held;
  logic [lbme_pkg::CHAN_W-1:0] cur_chan;

  logic                        cc_multi;
  logic                        cc_scale;
  logic [lbme_pkg::SLOT_W-1:0] cc_slot;
  logic [DW-1:0]               cc_num;
  logic [DW-1:0]               cc_val;
  logic [17:0]                 scale_prod;

  assign emit_ok   = !out_valid_r || out_ch.ready;
  assign cur_voice = (state_r == lbme_pkg::BK_STOP_OFF || state_r == lbme_pkg::BK_STOP_CC) ?
                     vc_r : op_r.voice;
  assign cur_chan  = cfg.voice_channels[cur_voice];

  always_comb begin
    cur_held  = 1'b0;
    cur_note  = '0;
    head_held = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      if (VW'(i) == cur_voice) begin
        cur_held = held_valid_r[i];
        cur_note = held_note_r[i];
      end
      if (VW'(i) == head_op.voice) begin
        head_held = held_valid_r[i];
      end
    end
  end

  // Control change: slot and value from the data byte.
  assign cc_multi   = cfg.cc_multi_mode[op_r.voice];
  assign cc_scale   = cfg.cc_scaling[op_r.voice];
  assign scale_prod = 18'(op_r.data) * SCALE_RECIP;

  always_comb begin
    cc_slot = cc_multi ? op_r.data[6:4] : '0;
    if (cc_slot > lbme_pkg::SLOT_W'(CC_SLOTS - 1)) begin
      cc_slot = lbme_pkg::SLOT_W'(CC_SLOTS - 1);
    end
    cc_num = cfg.cc_numbers[op_r.voice][cc_slot];
    if (!cc_scale) begin
      cc_val = op_r.data;
    end else if (cc_multi) begin
      cc_val = {op_r.data[3:0], 3'b000};
    end else begin
      cc_val = op_r.data + DW'(scale_prod[17:SCALE_SHIFT]);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbme_pkg::BK_IDLE: begin
        if (head_valid) begin
          if (head_op.kind == lbme_pkg::OP_NOTE) begin
            if (head_held) begin
              state_nxt = lbme_pkg::BK_NOTE_OFF;
            end else if (head_op.data != '0) begin
              state_nxt = lbme_pkg::BK_NOTE_ON;
            end
          end else if (head_op.kind == lbme_pkg::OP_STOP) begin
            state_nxt = lbme_pkg::BK_STOP_OFF;
          end else begin
            state_nxt = lbme_pkg::BK_SINGLE;
          end
        end
      end
      lbme_pkg::BK_NOTE_OFF: begin
        if (emit_ok) begin
          state_nxt = (op_r.data != '0) ? lbme_pkg::BK_NOTE_ON : lbme_pkg::BK_IDLE;
        end
      end
      lbme_pkg::BK_NOTE_ON, lbme_pkg::BK_SINGLE, lbme_pkg::BK_STOP_END: begin
        if (emit_ok) begin
          state_nxt = lbme_pkg::BK_IDLE;
        end
      end
      lbme_pkg::BK_STOP_OFF: begin
        if (!cur_held || emit_ok) begin
          state_nxt = lbme_pkg::BK_STOP_CC;
        end
      end
      lbme_pkg::BK_STOP_CC: begin
        if (emit_ok) begin
          state_nxt = (vc_r == VW'(VOICES - 1)) ? lbme_pkg::BK_STOP_END :
                      lbme_pkg::BK_STOP_OFF;
        end
      end
      default: state_nxt = lbme_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop      = 1'b0;
    load     = 1'b0;
    emit     = 1'b0;
    ev_kind  = lbme_pkg::EV_CLOCK;
    ev_chan  = '0;
    ev_d1    = '0;
    ev_d2    = '0;
    ev_last  = 1'b0;
    set_held = 1'b0;
    clr_held = 1'b0;
    vc_inc   = 1'b0;
    unique case (state_r)
      lbme_pkg::BK_IDLE: begin
        pop  = head_valid;
        load = head_valid;
      end
      lbme_pkg::BK_NOTE_OFF: begin
        emit     = emit_ok;
        ev_kind  = lbme_pkg::EV_NOTE_OFF;
        ev_chan  = cur_chan;
        ev_d1    = cur_note;
        ev_d2    = VEL_OFF;
        ev_last  = (op_r.data == '0);
        clr_held = emit_ok;
      end
      lbme_pkg::BK_NOTE_ON: begin
        emit     = emit_ok;
        ev_kind  = lbme_pkg::EV_NOTE_ON;
        ev_chan  = cur_chan;
        ev_d1    = op_r.data;
        ev_d2    = VEL_ON;
        ev_last  = 1'b1;
        set_held = emit_ok;
      end
      lbme_pkg::BK_SINGLE: begin
        emit    = emit_ok;
        ev_last = 1'b1;
        unique case (op_r.kind)
          lbme_pkg::OP_START: ev_kind = lbme_pkg::EV_START;
          lbme_pkg::OP_CC: begin
            ev_kind = lbme_pkg::EV_CC;
            ev_chan = cur_chan;
            ev_d1   = cc_num;
            ev_d2   = cc_val;
          end
          lbme_pkg::OP_PROG: begin
            ev_kind = lbme_pkg::EV_PROG;
            ev_chan = cur_chan;
            ev_d1   = op_r.data;
          end
          default: ev_kind = lbme_pkg::EV_CLOCK;
        endcase
      end
      lbme_pkg::BK_STOP_OFF: begin
        emit     = cur_held && emit_ok;
        ev_kind  = lbme_pkg::EV_NOTE_OFF;
        ev_chan  = cur_chan;
        ev_d1    = cur_note;
        ev_d2    = VEL_OFF;
        clr_held = cur_held && emit_ok;
      end
      lbme_pkg::BK_STOP_CC: begin
        emit    = emit_ok;
        ev_kind = lbme_pkg::EV_CC;
        ev_chan = cur_chan;
        ev_d1   = CC_ALL_OFF;
        vc_inc  = emit_ok;
      end
      lbme_pkg::BK_STOP_END: begin
        emit    = emit_ok;
        ev_kind = lbme_pkg::EV_STOP;
        ev_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lbme_pkg::BK_IDLE;
      vc_r         <= '0;
      held_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        vc_r <= '0;
      end else if (vc_inc) begin
        vc_r <= vc_r + 1'b1;
      end
      for (int i = 0; i < VOICES; i++) begin
        if (clr_held && VW'(i) == cur_voice) begin
          held_valid_r[i] <= 1'b0;
        end else if (set_held && VW'(i) == op_r.voice) begin
          held_valid_r[i] <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= head_op;
    end
    for (int i = 0; i < VOICES; i++) begin
      if (set_held && VW'(i) == op_r.voice) begin
        held_note_r[i] <= op_r.data;
      end
    end
    if (emit) begin
      out_kind_r <= ev_kind;
      out_chan_r <= ev_chan;
      out_d1_r   <= ev_d1;
      out_d2_r   <= ev_d2;
      out_last_r <= ev_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.midi_channel = out_chan_r;
  assign out_ch.first_data   = out_d1_r;
  assign out_ch.second_data  = out_d2_r;
  assign out_ch.last_of_run  = out_last_r;

endmodule

// ===== hdl/link_byte_to_midi_event_decoder.sv =====
// Decodes bytes from a serial link into MIDI events.
// in_ch carries one link byte per transaction; out_ch carries one MIDI event
// per transaction, with last_of_run marking the final event caused by a byte.
// The cfg_ port writes one configuration register per cycle while cfg_we is
// high; it is meant to be used only while no byte is in flight.
// A front end tracks the pending command and turns bytes into work items
// that go into a two-entry queue; an event sequencer drains the queue and
// emits the events one at a time through an output register.
// The front end pushes each work item into the queue; the sequencer loads one
// item at a time in its idle state while the queue takes further bytes, and
// registers each event in the output register. Command bytes that only store
// a pending command, and data bytes that are dropped, are handled by the front
// end alone and put nothing in the queue.
// A stalled receiver holds the current event in the output register; the
// sequencer then waits, the queue fills, and in_ch.ready drops when it is full.
// Reset clears the pending command, the held notes, the queue and the output,
// and loads the configuration reset values (channels 0, 1, 2, 3 for the voices).
module link_byte_to_midi_event_decoder #(
  parameter int unsigned VOICES   = 4,
  parameter int unsigned CC_SLOTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lbme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbme_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  lbme_in_if.sink                           in_ch,
  lbme_out_if.source                        out_ch
);

  lbme_pkg::cfg_t cfg_r;

  logic          push;
  lbme_pkg::op_t push_op;
  logic          push_ready;
  logic          pop;
  lbme_pkg::op_t head_op;
  logic          head_valid;

  // Configuration registers. Writes to an index past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voice_channels <= lbme_pkg::VOICE_CHANNELS_RESET;
      cfg_r.cc_multi_mode  <= '0;
      cfg_r.cc_scaling     <= '0;
      cfg_r.cc_numbers     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbme_pkg::CFG_VOICE_CHANNELS: cfg_r.voice_channels <= cfg_wdata[15:0];
        lbme_pkg::CFG_CC_MULTI_MODE:  cfg_r.cc_multi_mode  <= cfg_wdata[3:0];
        lbme_pkg::CFG_CC_SCALING:     cfg_r.cc_scaling     <= cfg_wdata[3:0];
        lbme_pkg::CFG_CC_NUMBERS0:    cfg_r.cc_numbers[0]  <= cfg_wdata;
        lbme_pkg::CFG_CC_NUMBERS1:    cfg_r.cc_numbers[1]  <= cfg_wdata;
        lbme_pkg::CFG_CC_NUMBERS2:    cfg_r.cc_numbers[2]  <= cfg_wdata;
        lbme_pkg::CFG_CC_NUMBERS3:    cfg_r.cc_numbers[3]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: accepts every byte the queue has room for.
  lbme_front #(
    .VOICES (VOICES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  lbme_op_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop        (pop),
    .head_op    (head_op),
    .head_valid (head_valid)
  );

  // Event sequencer: emits its events one at a time, waiting while the output register is full.
  lbme_back #(
    .VOICES   (VOICES),
    .CC_SLOTS (CC_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_op    (head_op),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
